>>> rtl/segment_allocator_best_worst_fit_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment allocator
// Shorthand for clocked checks held off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ALLOCATOR_BEST_WORST_FIT_CORE_ASSERT_SVH
`define SEGMENT_ALLOCATOR_BEST_WORST_FIT_CORE_ASSERT_SVH

// check that a condition holds whenever the antecedent holds
`define SABWF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check that a condition holds in the cycle after the antecedent
`define SABWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sabwf_pkg.sv
// ----------------------------------------------------------------------------
// sabwf_pkg
// Command, status and sequencer state codes of the segment allocator.
// ----------------------------------------------------------------------------
package sabwf_pkg;

  localparam int OWNER_W = 24;
  localparam int SIZE_W  = 16;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_EXACT,
    S_UP,
    S_LO,
    S_HI,
    S_FRD,
    S_FNX,
    S_MERGE,
    S_DN,
    S_DONE
  } state_t;

endpackage

>>> rtl/sabwf_table.sv
// ----------------------------------------------------------------------------
// sabwf_table
// Segment table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sabwf_table import sabwf_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 57
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/segment_allocator_best_worst_fit_core.sv
// ----------------------------------------------------------------------------
// segment_allocator_best_worst_fit_core
// Best-fit / worst-fit segment allocator over an address-ordered table.
// ----------------------------------------------------------------------------
// Requests enter on s_* (tuser = command, tdata = owner id and size); one result per
// request leaves on m_* (tuser = status). One request at a time: a small sequencer walks
// the table through one registered read port and one write port, one entry per cycle.
// Init, an unused command and trivial rejects go straight to the done state. Allocate
// scans the table (stopping early when best fit meets an exact fit), then marks an
// exact fit used in place, rejects a split when the table is full, or shifts the later
// entries up and writes both halves of the split; then it loads the result. Free scans
// for the owner, merges it with free neighbours, shifts the later entries down to close
// the gap and loads the result.
// The result sits in an output register and s_tready returns the cycle after it is
// loaded, so a new request may be taken while it waits. A stalled receiver holds the
// core in its done state until the output register frees up.
// Reset empties the table (entries are not cleared) and sets best fit, memory_size 65535.
// Config writes act at any edge; issue them only while no request is in flight.
// ----------------------------------------------------------------------------
module segment_allocator_best_worst_fit_core import sabwf_pkg::*; #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ADDR_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [23:0] process_id, [39:24] request_size
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] alloc_start, [31:16] remaining
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW   = ADDR_WIDTH;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int NW   = $clog2(MAX_SEGMENTS + 1);
  localparam int CW   = (AW > SIZE_W) ? AW : SIZE_W;
  localparam int EW   = 1 + OWNER_W + 2 * AW;
  localparam logic [NW-1:0] MAXN = NW'(MAX_SEGMENTS);

  // config registers
  logic               fit_policy;
  logic [SIZE_W-1:0]  memory_size;

  state_t state, state_next;

  // request
  cmd_t                cmd;
  logic [OWNER_W-1:0]  pid;
  logic [SIZE_W-1:0]   req_size;

  // sequencer
  logic [NW-1:0] count;
  logic [NW-1:0] j;
  logic [NW-1:0] rq_idx;
  logic          rdv;
  logic          found;
  logic          stop;

  // alloc choice
  logic [IW-1:0] pick;
  logic [AW-1:0] best;
  logic [AW-1:0] pick_base;

  // free merge
  logic [IW-1:0] hit;
  logic [AW-1:0] hit_base;
  logic [AW-1:0] merge;
  logic          prev_used;
  logic [AW-1:0] prev_base;
  logic [AW-1:0] prev_len;
  logic          next_free;
  logic [1:0]    shift_d;

  // pending result and output register
  status_t             res_status;
  logic [SIZE_W-1:0]   res_start;
  logic [SIZE_W-1:0]   res_rem;
  status_t             out_status;
  logic [SIZE_W-1:0]   out_start;
  logic [SIZE_W-1:0]   out_rem;

  // table port
  logic          rd_en;
  logic [IW-1:0] rd_idx;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] rd_data;

  logic               rd_used;
  logic [OWNER_W-1:0] rd_owner;
  logic [AW-1:0]      rd_base;
  logic [AW-1:0]      rd_len;

  logic          acc;
  logic          cand;
  logic [AW-1:0] rmd;
  logic          scan_end;
  logic          pf;
  logic [1:0]    mg_d;
  logic [NW-1:0] mg_dst;
  logic          out_free;

  sabwf_table #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  assign {rd_used, rd_owner, rd_base, rd_len} = rd_data;

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // fit test on the entry just read
  assign cand = !rd_used && (CW'(rd_len) >= CW'(req_size));
  assign rmd  = AW'(CW'(rd_len) - CW'(req_size));

  assign scan_end = stop || ((j == count) && !rdv);

  // free: merge with left and right holes, drop none, one or two entries
  assign pf     = (hit != '0) && !prev_used;
  assign mg_d   = {1'b0, pf} + {1'b0, next_free};
  assign mg_dst = pf ? NW'(hit) : NW'(hit) + NW'(1);

  assign m_tuser = out_status;
  assign m_tdata = {out_rem, out_start};

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= 1'b0;
      memory_size <= 16'hFFFF;
    end else if (cfg_we) begin
      if (cfg_index) begin
        memory_size <= cfg_data;
      end else begin
        fit_policy <= cfg_data[0];
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd_t'(s_tuser))
            CMD_ALLOC: begin
              if (s_tdata[39:24] == '0 || s_tdata[23:0] == '0 || count == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_SCAN;
              end
            end
            CMD_FREE: begin
              state_next = (s_tdata[23:0] == '0) ? S_DONE : S_SCAN;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          if (!found) begin
            state_next = S_DONE;
          end else if (cmd == CMD_ALLOC) begin
            if (best == '0) begin
              state_next = S_EXACT;
            end else if (count == MAXN) begin
              state_next = S_DONE;
            end else if (count - NW'(1) > NW'(pick)) begin
              state_next = S_UP;
            end else begin
              state_next = S_LO;
            end
          end else if (NW'(hit) + NW'(1) < count) begin
            state_next = S_FRD;
          end else begin
            state_next = S_MERGE;
          end
        end
      end
      S_EXACT: state_next = S_DONE;
      S_UP: begin
        if (!(j > NW'(pick)) && !rdv) begin
          state_next = S_LO;
        end
      end
      S_LO:  state_next = S_HI;
      S_HI:  state_next = S_DONE;
      S_FRD: state_next = S_FNX;
      S_FNX: state_next = S_MERGE;
      S_MERGE: begin
        state_next = (mg_d == 2'd0) ? S_DONE : S_DN;
      end
      S_DN: begin
        if (!(j < count) && !rdv) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = j[IW-1:0];
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = '0;
    case (state)
      S_IDLE: begin
        wr_en   = acc && (cmd_t'(s_tuser) == CMD_INIT);
        wr_data = {1'b0, OWNER_W'(0), AW'(0), AW'(memory_size)};
      end
      S_SCAN: begin
        rd_en = (j < count) && !stop;
      end
      S_EXACT: begin
        wr_en   = 1'b1;
        wr_idx  = pick;
        wr_data = {1'b1, pid, pick_base, AW'(req_size)};
      end
      S_UP: begin
        rd_en   = j > NW'(pick);
        wr_en   = rdv;
        wr_idx  = IW'(rq_idx + NW'(1));
        wr_data = rd_data;
      end
      S_LO: begin
        wr_en   = 1'b1;
        wr_idx  = pick;
        wr_data = {1'b0, OWNER_W'(0), pick_base, best};
      end
      S_HI: begin
        wr_en   = 1'b1;
        wr_idx  = IW'(NW'(pick) + NW'(1));
        wr_data = {1'b1, pid, AW'(pick_base + best), AW'(req_size)};
      end
      S_FRD: begin
        rd_en  = 1'b1;
        rd_idx = IW'(NW'(hit) + NW'(1));
      end
      S_MERGE: begin
        wr_en = 1'b1;
        if (pf) begin
          wr_idx  = hit - IW'(1);
          wr_data = {1'b0, OWNER_W'(0), prev_base, AW'(prev_len + merge)};
        end else begin
          wr_idx  = hit;
          wr_data = {1'b0, OWNER_W'(0), hit_base, merge};
        end
      end
      S_DN: begin
        rd_en   = j < count;
        wr_en   = rdv;
        wr_idx  = IW'(rq_idx - NW'(shift_d));
        wr_data = rd_data;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rdv      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      rdv   <= rd_en && (state_next == state);
      if (acc && cmd_t'(s_tuser) == CMD_INIT) begin
        count <= NW'(1);
      end
      if (state == S_HI) begin
        count <= count + NW'(1);
      end
      if (state == S_DN && state_next == S_DONE) begin
        count <= count - NW'(shift_d);
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rq_idx <= j;
    end
    case (state)
      S_IDLE: begin
        cmd       <= cmd_t'(s_tuser);
        pid       <= s_tdata[23:0];
        req_size  <= s_tdata[39:24];
        j         <= '0;
        found     <= 1'b0;
        stop      <= 1'b0;
        next_free <= 1'b0;
        prev_used <= 1'b1;
        res_start <= '0;
        res_rem   <= '0;
        case (cmd_t'(s_tuser))
          CMD_ALLOC: res_status <= ST_NOFIT;
          CMD_FREE:  res_status <= ST_NOTFOUND;
          default:   res_status <= ST_OK;
        endcase
      end
      S_SCAN: begin
        if (rd_en) begin
          j <= j + NW'(1);
        end
        if (rdv && !stop) begin
          if (cmd == CMD_ALLOC) begin
            if (cand) begin
              if (!fit_policy && rmd == '0) begin
                pick      <= IW'(rq_idx);
                best      <= '0;
                pick_base <= rd_base;
                found     <= 1'b1;
                stop      <= 1'b1;
              end else if (!found || (!fit_policy && rmd < best) ||
                           (fit_policy && rmd > best)) begin
                pick      <= IW'(rq_idx);
                best      <= rmd;
                pick_base <= rd_base;
                found     <= 1'b1;
              end
            end
          end else begin
            if (rd_used && rd_owner == pid) begin
              hit      <= IW'(rq_idx);
              hit_base <= rd_base;
              merge    <= rd_len;
              found    <= 1'b1;
              stop     <= 1'b1;
            end else begin
              prev_used <= rd_used;
              prev_base <= rd_base;
              prev_len  <= rd_len;
            end
          end
        end
        if (scan_end) begin
          j <= count - NW'(1);
          if (found && cmd == CMD_ALLOC && best != '0 && count == MAXN) begin
            res_status <= ST_FULL;
          end
        end
      end
      S_EXACT: begin
        res_status <= ST_OK;
        res_start  <= SIZE_W'(pick_base);
      end
      S_UP: begin
        if (rd_en) begin
          j <= j - NW'(1);
        end
      end
      S_HI: begin
        res_status <= ST_OK;
        res_start  <= SIZE_W'(AW'(pick_base + best));
        res_rem    <= SIZE_W'(best);
      end
      S_FNX: begin
        next_free <= !rd_used;
        if (!rd_used) begin
          merge <= AW'(merge + rd_len);
        end
      end
      S_MERGE: begin
        res_status <= ST_OK;
        j          <= mg_dst + NW'(mg_d);
        shift_d    <= mg_d;
      end
      S_DN: begin
        if (rd_en) begin
          j <= j + NW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status <= res_status;
          out_start  <= res_start;
          out_rem    <= res_rem;
        end
      end
      default: ;
    endcase
  end

  `include "segment_allocator_best_worst_fit_core_assert.svh"

  `SABWF_ASSERT_SAME(a_count_bound, 1'b1, count <= MAXN, "segment count above table depth")
  `SABWF_ASSERT_SAME(a_read_in_table, rdv, rq_idx < count, "table read beyond count")
  `SABWF_ASSERT_NEXT(a_init_count, acc && cmd_t'(s_tuser) == CMD_INIT, count == NW'(1), "init did not leave one segment")
  `SABWF_ASSERT_SAME(a_ready_idle, s_tready, !rdv && !wr_en || acc, "table busy while ready")

endmodule

>>> test/tb_segment_allocator_checker.sv
// ----------------------------------------------------------------------------
// Segment allocator checker
// Watches the request and result streams, keeps its own copy of the segment
// table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_segment_allocator_checker import sabwf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = 16;

  typedef struct packed {
    status_t     status;
    logic [15:0] start;
    logic [15:0] rem;
  } alloc_result_t;

  logic        policy_worst;
  logic [15:0] mem_words;
  logic        hole_used [NSEG];
  logic [23:0] hole_owner [NSEG];
  logic [15:0] hole_base [NSEG];
  logic [15:0] hole_len [NSEG];
  int          table_count;
  alloc_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic void remove_entry(int idx);
    for (int k = idx; k + 1 < table_count; k++) begin
      hole_used[k]  = hole_used[k+1];
      hole_owner[k] = hole_owner[k+1];
      hole_base[k]  = hole_base[k+1];
      hole_len[k]   = hole_len[k+1];
    end
    table_count--;
  endfunction

  function automatic alloc_result_t predict_allocator(cmd_t cmd, logic [23:0] id,
                                                      logic [15:0] size);
    alloc_result_t r;
    int          pick;
    bit          found;
    logic [15:0] best;
    logic [15:0] rest;
    r = '{ST_OK, 16'd0, 16'd0};
    pick = 0;
    found = 0;
    best = 0;
    case (cmd)
      CMD_ALLOC: begin
        if (size == 0 || id == 0) return '{ST_NOFIT, 16'd0, 16'd0};
        for (int i = 0; i < table_count; i++) begin
          if (hole_used[i] || hole_len[i] < size) continue;
          rest = hole_len[i] - size;
          if (!policy_worst) begin
            if (rest == 0) begin
              pick = i; found = 1; best = 0;
              break;
            end
            if (!found || rest < best) begin
              pick = i; best = rest; found = 1;
            end
          end else if (!found || rest > best) begin
            pick = i; best = rest; found = 1;
          end
        end
        if (!found) return '{ST_NOFIT, 16'd0, 16'd0};
        if (best == 0) begin
          hole_used[pick] = 1;
          hole_owner[pick] = id;
          return '{ST_OK, hole_base[pick], 16'd0};
        end
        if (table_count >= NSEG) return '{ST_FULL, 16'd0, 16'd0};
        for (int k = table_count; k > pick + 1; k--) begin
          hole_used[k]  = hole_used[k-1];
          hole_owner[k] = hole_owner[k-1];
          hole_base[k]  = hole_base[k-1];
          hole_len[k]   = hole_len[k-1];
        end
        hole_len[pick] = best;
        hole_used[pick+1] = 1;
        hole_owner[pick+1] = id;
        hole_base[pick+1] = hole_base[pick] + best;
        hole_len[pick+1] = size;
        table_count++;
        r = '{ST_OK, hole_base[pick+1], best};
      end
      CMD_FREE: begin
        if (id == 0) return '{ST_NOTFOUND, 16'd0, 16'd0};
        for (int i = 0; i < table_count; i++) begin
          if (hole_used[i] && hole_owner[i] == id) begin
            hole_used[i] = 0;
            hole_owner[i] = 0;
            if (i + 1 < table_count && !hole_used[i+1]) begin
              hole_len[i] = hole_len[i] + hole_len[i+1];
              remove_entry(i + 1);
            end
            if (i > 0 && !hole_used[i-1]) begin
              hole_len[i-1] = hole_len[i-1] + hole_len[i];
              remove_entry(i);
            end
            return r;
          end
        end
        r.status = ST_NOTFOUND;
      end
      CMD_INIT: begin
        table_count = 1;
        hole_used[0] = 0;
        hole_owner[0] = 0;
        hole_base[0] = 0;
        hole_len[0] = mem_words;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      policy_worst <= 0;
      mem_words <= 16'hFFFF;
      table_count = 0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) policy_worst <= cfg_data[0];
        else mem_words <= cfg_data;
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_allocator(cmd_t'(s_tuser), s_tdata[23:0],
                                                     s_tdata[39:24]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d start=%0d rem=%0d", $time,
                   m_tuser, m_tdata[15:0], m_tdata[31:16]);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status || m_tdata[15:0] !== want.start ||
              m_tdata[31:16] !== want.rem) begin
            $display("%0t: mismatch expected status=%0d start=%0d rem=%0d, actual %0d %0d %0d",
                     $time, want.status, want.start, want.rem,
                     m_tuser, m_tdata[15:0], m_tdata[31:16]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Segment allocator testbench
// Drives allocate, free and init requests with random flow control and
// several policy / memory size settings; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top import sabwf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          quiet_cycles;
  logic [23:0] live_ids[$];

  always #5 clk = ~clk;

  segment_allocator_best_worst_fit_core i_dut (.*);

  tb_segment_allocator_checker i_checker (.*);

  // receiver: random stall per the current idling phase
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one request; sender idles at random first. s_tready only moves at the rising
  // edge, so its value at the falling edge tells whether the next edge accepts.
  // tvalid stays up on return: the block is never ready the edge after an accept.
  task automatic send_request(cmd_t cmd, logic [23:0] id, logic [15:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {size, id};
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    if (cmd == CMD_ALLOC && id != 0) live_ids.push_back(id);
  endtask

  // wait for the table to settle, then write one register
  task automatic write_register(logic idx, logic [15:0] value);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // mostly sizes small against the memory, with live ids freed often
  task automatic random_request(logic [15:0] mem);
    int          pick;
    logic [23:0] id;
    pick = $urandom_range(99);
    if (pick < 50) begin
      id = 24'($urandom_range(1, 40));
      if ($urandom_range(19) == 0) id = 24'($urandom);
      send_request(CMD_ALLOC, id,
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, mem / 4 + 1)));
    end else if (pick < 85) begin
      if (live_ids.size() != 0 && $urandom_range(3) != 0) begin
        pick = $urandom_range(live_ids.size() - 1);
        id = live_ids[pick];
        live_ids.delete(pick);
      end else id = 24'($urandom);
      send_request(CMD_FREE, id, 16'($urandom));
    end else if (pick < 90) begin
      send_request(CMD_INIT, 24'($urandom), 16'($urandom));
      live_ids.delete();
    end else if (pick < 93) begin
      send_request(CMD_NONE, 24'($urandom), 16'($urandom));
    end else begin
      send_request(CMD_ALLOC, 24'($urandom_range(1, 40)), 16'($urandom_range(1, 3)));
    end
  endtask

  initial begin
    logic [15:0] sizes[5];
    sizes = '{16'd100, 16'd65535, 16'd1, 16'd0, 16'd4000};
    send_idle_pct = 20;
    recv_idle_pct = 65;
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // empty table, unused command, zero id and zero size
    send_request(CMD_ALLOC, 24'd5, 16'd10);
    send_request(CMD_FREE, 24'd5, 16'd0);
    send_request(CMD_NONE, 24'hFFFFFF, 16'hFFFF);
    send_request(CMD_INIT, 24'd0, 16'd0);
    send_request(CMD_ALLOC, 24'd0, 16'd10);
    send_request(CMD_ALLOC, 24'd7, 16'd0);
    send_request(CMD_FREE, 24'd0, 16'd0);
    send_request(CMD_ALLOC, 24'hFFFFFF, 16'hFFFF);
    send_request(CMD_FREE, 24'hFFFFFF, 16'd0);
    // fill the table with single words to reach the full-table case
    for (int i = 1; i <= 16; i++) send_request(CMD_ALLOC, 24'(i), 16'd1);
    send_request(CMD_FREE, 24'd3, 16'd0);
    send_request(CMD_FREE, 24'd4, 16'd0);
    send_request(CMD_ALLOC, 24'd99, 16'd2);

    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 20;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(1'b0, 16'(phase % 2));
      write_register(1'b1, sizes[phase % 5]);
      live_ids.delete();
      send_request(CMD_INIT, 24'd1, 16'd0);
      for (int n = 0; n < 48; n++) random_request(sizes[phase % 5]);
    end

    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
